// ----- hw/rtl/aar_pkg.sv -----
// ----------------------------------------------------------------------------
// aar_pkg
// Shared types, register indexes and helpers of the affine axis remapper.
// ----------------------------------------------------------------------------
package aar_pkg;

   localparam int AXIS_W     = 16;
   localparam int COEF_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PAIRED_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RANGE_MIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RANGE_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_CENTERED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RANGE_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RANGE_MAX = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_CENTERED  = 3'd6;

   typedef enum logic [1:0] {
      NK_ZERO,
      NK_NEG_ONE,
      NK_POS_ONE,
      NK_DIV
   } norm_kind_type;

   typedef struct packed {
      logic [COEF_W-1:0] coef_xx;
      logic [COEF_W-1:0] coef_xy;
      logic [COEF_W-1:0] coef_yx;
      logic [COEF_W-1:0] coef_yy;
      logic [COEF_W-1:0] offset_u;
      logic [COEF_W-1:0] offset_v;
      norm_kind_type     x_kind;
      logic              x_neg;
      norm_kind_type     y_kind;
      logic              y_neg;
   } side_type;

   // midpoint of a range, truncated toward zero
   function automatic logic signed [AXIS_W-1:0] axis_center(
      input logic signed [AXIS_W-1:0] lo,
      input logic signed [AXIS_W-1:0] hi
   );
      logic signed [AXIS_W:0] s;
      logic signed [AXIS_W:0] t;
      s = {lo[AXIS_W-1], lo} + {hi[AXIS_W-1], hi};
      t = s + {{AXIS_W{1'b0}}, s[AXIS_W] & s[0]};
      return t[AXIS_W:1];
   endfunction

endpackage

// ----- hw/rtl/aar_norm.sv -----
// ----------------------------------------------------------------------------
// aar_norm
// Classifies a raw axis sample against its range and sets up the divide.
// ----------------------------------------------------------------------------
module aar_norm (
   input  logic signed [aar_pkg::AXIS_W-1:0] val,
   input  logic signed [aar_pkg::AXIS_W-1:0] range_min,
   input  logic signed [aar_pkg::AXIS_W-1:0] range_max,
   input  logic                              centered,
   output aar_pkg::norm_kind_type            kind,
   output logic                              neg,
   output logic [aar_pkg::AXIS_W:0]          num,
   output logic [aar_pkg::AXIS_W:0]          den
);
   import aar_pkg::*;

   logic signed [AXIS_W-1:0] c;
   logic signed [AXIS_W:0]   d_cv, d_clo, d_vc, d_hc, d_vlo, d_hlo;

   always_comb begin
      c     = axis_center(range_min, range_max);
      d_cv  = {c[AXIS_W-1], c} - {val[AXIS_W-1], val};
      d_clo = {c[AXIS_W-1], c} - {range_min[AXIS_W-1], range_min};
      d_vc  = {val[AXIS_W-1], val} - {c[AXIS_W-1], c};
      d_hc  = {range_max[AXIS_W-1], range_max} - {c[AXIS_W-1], c};
      d_vlo = {val[AXIS_W-1], val} - {range_min[AXIS_W-1], range_min};
      d_hlo = {range_max[AXIS_W-1], range_max} - {range_min[AXIS_W-1], range_min};
      kind = NK_ZERO;
      neg  = 1'b0;
      num  = d_vlo;
      den  = d_hlo;
      if (centered) begin
         if (val <= range_min) begin
            kind = NK_NEG_ONE;
         end else if (val < c) begin
            kind = NK_DIV;
            neg  = 1'b1;
            num  = d_cv;
            den  = d_clo;
         end else if (val == c) begin
            kind = NK_ZERO;
         end else if (val < range_max) begin
            kind = NK_DIV;
            num  = d_vc;
            den  = d_hc;
         end else begin
            kind = NK_POS_ONE;
         end
      end else begin
         if (val <= range_min) begin
            kind = NK_ZERO;
         end else if (val >= range_max) begin
            kind = NK_POS_ONE;
         end else begin
            kind = NK_DIV;
         end
      end
   end

endmodule

// ----- hw/rtl/aar_div.sv -----
// ----------------------------------------------------------------------------
// aar_div
// Pipelined restoring divider, one quotient bit per stage (num < den).
// ----------------------------------------------------------------------------
module aar_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic [FRAC_BITS-1:0]        en,
   input  logic [aar_pkg::AXIS_W:0]    num,
   input  logic [aar_pkg::AXIS_W:0]    den,
   output logic [FRAC_BITS-1:0]        quot
);
   import aar_pkg::*;

   logic [AXIS_W:0]    rem_ff [FRAC_BITS];
   logic [AXIS_W:0]    den_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      logic [AXIS_W:0]      rem_src, den_src, rem_in;
      logic [FRAC_BITS-1:0] q_src, q_in;
      logic [AXIS_W+1:0]    r2, dd;

      if (k == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign q_src   = q_ff[k-1];
      end

      always_comb begin
         r2 = {rem_src, 1'b0};
         dd = {1'b0, den_src};
         if (r2 >= dd) begin
            rem_in = (AXIS_W+1)'(r2 - dd);
            q_in   = {q_src[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = r2[AXIS_W:0];
            q_in   = {q_src[FRAC_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            q_ff[k]   <= q_in;
         end
      end
   end

   assign quot = q_ff[FRAC_BITS-1];

endmodule

// ----- hw/rtl/aar_affine.sv -----
// ----------------------------------------------------------------------------
// aar_affine
// Two-stage affine step: coefficient products, then sums with offsets.
// ----------------------------------------------------------------------------
module aar_affine #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic [1:0]                            en,
   input  logic                                  paired_mode,
   input  logic signed [FRAC_BITS+1:0]           nx,
   input  logic signed [FRAC_BITS+1:0]           ny,
   input  aar_pkg::side_type                     side,
   output logic signed [FRAC_BITS+aar_pkg::COEF_W+1:0] u,
   output logic signed [FRAC_BITS+aar_pkg::COEF_W+1:0] v
);
   import aar_pkg::*;

   localparam int UW = FRAC_BITS + COEF_W + 2;

   logic signed [UW-1:0]     pxx_ff, pxy_ff, pyx_ff, pyy_ff;
   logic signed [COEF_W-1:0] ou_ff, ov_ff;
   logic signed [UW-1:0]     ou_ext, ov_ext;
   logic signed [UW-1:0]     u_ff, v_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pxx_ff <= $signed(side.coef_xx) * nx;
         pxy_ff <= $signed(side.coef_xy) * ny;
         pyx_ff <= $signed(side.coef_yx) * nx;
         pyy_ff <= $signed(side.coef_yy) * ny;
         ou_ff  <= $signed(side.offset_u);
         ov_ff  <= $signed(side.offset_v);
      end
   end

   always_comb begin
      ou_ext = {{(UW-COEF_W){ou_ff[COEF_W-1]}}, ou_ff} <<< FRAC_BITS;
      ov_ext = {{(UW-COEF_W){ov_ff[COEF_W-1]}}, ov_ff} <<< FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         u_ff <= pxx_ff + (paired_mode ? pxy_ff : '0) + ou_ext;
         v_ff <= pyx_ff + pyy_ff + ov_ext;
      end
   end

   assign u = u_ff;
   assign v = v_ff;

endmodule

// ----- hw/rtl/aar_map.sv -----
// ----------------------------------------------------------------------------
// aar_map
// Maps a transformed value back to its axis range: split multiply,
// recombine, add base, then truncate toward zero, clamp and saturate.
// ----------------------------------------------------------------------------
module aar_map #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                        clock,
   input  logic [3:0]                                  en,
   input  logic signed [FRAC_BITS+aar_pkg::COEF_W+1:0] w,
   input  logic signed [aar_pkg::AXIS_W-1:0]           range_min,
   input  logic signed [aar_pkg::AXIS_W-1:0]           range_max,
   input  logic                                        centered,
   output logic signed [aar_pkg::AXIS_W-1:0]           result
);
   import aar_pkg::*;

   localparam int UW  = FRAC_BITS + COEF_W + 2;
   localparam int DW  = AXIS_W + 2;
   localparam int K   = (UW + 1) / 2;
   localparam int PLW = K + DW + 1;
   localparam int PHW = UW - K + DW;
   localparam int PW  = UW + DW;
   localparam int WT  = ((PW > 2*FRAC_BITS + AXIS_W + 1) ? PW : 2*FRAC_BITS + AXIS_W + 1) + 1;
   localparam int WR  = WT - 2*FRAC_BITS;

   logic signed [AXIS_W-1:0] c;
   logic signed [DW-1:0]     d;
   logic signed [AXIS_W-1:0] base;

   logic signed [PLW-1:0]    pl_ff;
   logic signed [PHW-1:0]    ph_ff;
   logic                     zero1_ff, neg1_ff;
   logic signed [AXIS_W-1:0] base1_ff;

   logic signed [PW-1:0]     p_ff;
   logic                     zero2_ff, neg2_ff;
   logic signed [AXIS_W-1:0] base2_ff;

   logic signed [WT-1:0]     t_ff;
   logic                     zero3_ff, neg3_ff;

   logic signed [AXIS_W-1:0] result_ff;
   logic signed [WR-1:0]     q, r, lo_e, hi_e, c_e;
   logic signed [AXIS_W-1:0] result_in;

   always_comb begin
      c = axis_center(range_min, range_max);
      if (centered) begin
         base = c;
         if (w[UW-1]) begin
            d = DW'(c) - DW'(range_min);
         end else begin
            d = DW'(range_max) - DW'(c);
         end
      end else begin
         base = range_min;
         d    = DW'(range_max) - DW'(range_min);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pl_ff    <= $signed({1'b0, w[K-1:0]}) * d;
         ph_ff    <= $signed(w[UW-1:K]) * d;
         zero1_ff <= (w == '0);
         neg1_ff  <= w[UW-1];
         base1_ff <= base;
      end
      if (en[1]) begin
         p_ff     <= (PW'(ph_ff) <<< K) + PW'(pl_ff);
         zero2_ff <= zero1_ff;
         neg2_ff  <= neg1_ff;
         base2_ff <= base1_ff;
      end
      if (en[2]) begin
         t_ff     <= WT'(p_ff) + (WT'(base2_ff) <<< (2*FRAC_BITS));
         zero3_ff <= zero2_ff;
         neg3_ff  <= neg2_ff;
      end
      if (en[3]) begin
         result_ff <= result_in;
      end
   end

   always_comb begin
      q = t_ff[WT-1:2*FRAC_BITS];
      if (t_ff[WT-1] && (t_ff[2*FRAC_BITS-1:0] != '0)) begin
         q = q + WR'(1);
      end
      lo_e = WR'(range_min);
      hi_e = WR'(range_max);
      c_e  = WR'(axis_center(range_min, range_max));
      r    = q;
      if (centered) begin
         if (zero3_ff) begin
            r = c_e;
         end else if (neg3_ff) begin
            if (q < lo_e) r = lo_e;
         end else begin
            if (q > hi_e) r = hi_e;
         end
      end else begin
         if (q < lo_e) begin
            r = lo_e;
         end else if (q > hi_e) begin
            r = hi_e;
         end
      end
      if ((&r[WR-1:AXIS_W-1]) || !(|r[WR-1:AXIS_W-1])) begin
         result_in = r[AXIS_W-1:0];
      end else if (r[WR-1]) begin
         result_in = {1'b1, {(AXIS_W-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(AXIS_W-1){1'b1}}};
      end
   end

   assign result = result_ff;

endmodule

// ----- hw/rtl/axis_affine_remap_top.sv -----
// ----------------------------------------------------------------------------
// axis_affine_remap_top
// Affine remapping of one or two controller axes.
//
// Usage: one transfer on req_ carries a raw x/y sample plus six Q(FRAC_BITS)
// coefficients; exactly one transfer on rsp_ returns the remapped x/y pair
// (in single mode y passes through raw), in order. Axis ranges, centering
// and paired/single mode come from the csr_ write port; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Throughput: one transfer per cycle while rsp_tready is high; every stage
// is a register with its own valid bit.
// Stall: a stage holds while it is full and the stage after it holds, so
// rsp_tready low backs the pipe up stage by stage; empty stages still
// accept, and req_tready drops only once the pipe is full.
// Reset: empties the pipe and loads the default ranges (full 16-bit span,
// centered, paired mode).
// ----------------------------------------------------------------------------
module axis_affine_remap_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // x_in, y_in, coef_xx, coef_xy, coef_yx, coef_yy, offset_u, offset_v
   input  logic [223:0]                           req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // x_out, y_out
   output logic [31:0]                            rsp_tdata,
   input  logic                                   csr_we,
   input  logic [aar_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [aar_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import aar_pkg::*;

   localparam int NSTG = FRAC_BITS + 8;
   localparam int NW   = FRAC_BITS + 2;
   localparam int UW   = FRAC_BITS + COEF_W + 2;
   localparam logic signed [NW-1:0] NORM_ONE = {2'b01, {FRAC_BITS{1'b0}}};

   logic                     paired_ff, x_cen_ff, y_cen_ff;
   logic signed [AXIS_W-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;

   logic [NSTG-1:0]          vld_ff, vld_in, en;

   side_type                 side_ff [FRAC_BITS+2];
   side_type                 side0_in;
   logic [AXIS_W-1:0]        yin_ff [NSTG];
   logic [AXIS_W:0]          xnum_ff, xden_ff, ynum_ff, yden_ff;
   logic [AXIS_W:0]          xnum, xden, ynum, yden;
   norm_kind_type            xkind, ykind;
   logic                     xneg, yneg;
   logic [FRAC_BITS-1:0]     xq, yq;
   logic signed [NW-1:0]     nx_ff, ny_ff, nx_in, ny_in;
   logic signed [UW-1:0]     u, v;
   logic signed [AXIS_W-1:0] x_res, y_res;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         paired_ff <= 1'b1;
         x_min_ff  <= {1'b1, {(AXIS_W-1){1'b0}}};
         x_max_ff  <= {1'b0, {(AXIS_W-1){1'b1}}};
         x_cen_ff  <= 1'b1;
         y_min_ff  <= {1'b1, {(AXIS_W-1){1'b0}}};
         y_max_ff  <= {1'b0, {(AXIS_W-1){1'b1}}};
         y_cen_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAIRED_MODE: paired_ff <= csr_wdata[0];
            CSR_X_RANGE_MIN: x_min_ff  <= csr_wdata;
            CSR_X_RANGE_MAX: x_max_ff  <= csr_wdata;
            CSR_X_CENTERED:  x_cen_ff  <= csr_wdata[0];
            CSR_Y_RANGE_MIN: y_min_ff  <= csr_wdata;
            CSR_Y_RANGE_MAX: y_max_ff  <= csr_wdata;
            CSR_Y_CENTERED:  y_cen_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage control
   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG-2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[0];

   // stage 0: classify
   aar_norm u_norm_x (
      .val       (req_tdata[15:0]),
      .range_min (x_min_ff),
      .range_max (x_max_ff),
      .centered  (x_cen_ff),
      .kind      (xkind),
      .neg       (xneg),
      .num       (xnum),
      .den       (xden)
   );

   aar_norm u_norm_y (
      .val       (req_tdata[31:16]),
      .range_min (y_min_ff),
      .range_max (y_max_ff),
      .centered  (y_cen_ff),
      .kind      (ykind),
      .neg       (yneg),
      .num       (ynum),
      .den       (yden)
   );

   always_comb begin
      side0_in.coef_xx  = req_tdata[63:32];
      side0_in.coef_xy  = req_tdata[95:64];
      side0_in.coef_yx  = req_tdata[127:96];
      side0_in.coef_yy  = req_tdata[159:128];
      side0_in.offset_u = req_tdata[191:160];
      side0_in.offset_v = req_tdata[223:192];
      side0_in.x_kind   = xkind;
      side0_in.x_neg    = xneg;
      side0_in.y_kind   = ykind;
      side0_in.y_neg    = yneg;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= side0_in;
         yin_ff[0]  <= req_tdata[31:16];
         xnum_ff    <= xnum;
         xden_ff    <= xden;
         ynum_ff    <= ynum;
         yden_ff    <= yden;
      end
      for (int k = 1; k < FRAC_BITS+2; k++) begin
         if (en[k]) side_ff[k] <= side_ff[k-1];
      end
      for (int k = 1; k < NSTG; k++) begin
         if (en[k]) yin_ff[k] <= yin_ff[k-1];
      end
   end

   // stages 1..FRAC_BITS: divide
   aar_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock),
      .en    (en[FRAC_BITS:1]),
      .num   (xnum_ff),
      .den   (xden_ff),
      .quot  (xq)
   );

   aar_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock),
      .en    (en[FRAC_BITS:1]),
      .num   (ynum_ff),
      .den   (yden_ff),
      .quot  (yq)
   );

   // normalized values
   always_comb begin
      case (side_ff[FRAC_BITS].x_kind)
         NK_NEG_ONE: nx_in = -NORM_ONE;
         NK_POS_ONE: nx_in = NORM_ONE;
         NK_DIV:     nx_in = side_ff[FRAC_BITS].x_neg ? -$signed({2'b00, xq})
                                                      : $signed({2'b00, xq});
         default:    nx_in = '0;
      endcase
      case (side_ff[FRAC_BITS].y_kind)
         NK_NEG_ONE: ny_in = -NORM_ONE;
         NK_POS_ONE: ny_in = NORM_ONE;
         NK_DIV:     ny_in = side_ff[FRAC_BITS].y_neg ? -$signed({2'b00, yq})
                                                      : $signed({2'b00, yq});
         default:    ny_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[FRAC_BITS+1]) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
      end
   end

   // affine transform
   aar_affine #(.FRAC_BITS(FRAC_BITS)) u_affine (
      .clock       (clock),
      .en          (en[FRAC_BITS+3:FRAC_BITS+2]),
      .paired_mode (paired_ff),
      .nx          (nx_ff),
      .ny          (ny_ff),
      .side        (side_ff[FRAC_BITS+1]),
      .u           (u),
      .v           (v)
   );

   // map back
   aar_map #(.FRAC_BITS(FRAC_BITS)) u_map_x (
      .clock     (clock),
      .en        (en[FRAC_BITS+7:FRAC_BITS+4]),
      .w         (u),
      .range_min (x_min_ff),
      .range_max (x_max_ff),
      .centered  (x_cen_ff),
      .result    (x_res)
   );

   aar_map #(.FRAC_BITS(FRAC_BITS)) u_map_y (
      .clock     (clock),
      .en        (en[FRAC_BITS+7:FRAC_BITS+4]),
      .w         (v),
      .range_min (y_min_ff),
      .range_max (y_max_ff),
      .centered  (y_cen_ff),
      .result    (y_res)
   );

   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {(paired_ff ? y_res : yin_ff[NSTG-1]), x_res};

endmodule
